[src/dual_accel_tilt_angles_defines.svh]
// ----------------------------------------------------------------------------
// dual_accel_tilt_angles_defines
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_ACCEL_TILT_ANGLES_DEFINES_SVH
`define DUAL_ACCEL_TILT_ANGLES_DEFINES_SVH

// clocked assertion, off while reset is high
`define DAT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds through reset
`define DAT_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/dat_pkg.sv]
// ----------------------------------------------------------------------------
// dat_pkg
// Constants and the angle table of the tilt angle pipeline.
// ----------------------------------------------------------------------------
package dat_pkg;

   localparam int GUARD_FRAC   = 20;
   localparam int CORDIC_STEPS = 27;
   localparam int ISQRT_STEPS  = 30;
   localparam int NORM_S_W     = 60;
   localparam int NORM_N_W     = 30;
   localparam int NORM_S_LIM   = 58;
   localparam int NORM_N_LIM   = 29;
   localparam int NORM_PASSES  = 5;
   localparam int XY_W         = 34;
   localparam int Z_W          = 29;
   localparam int TAB_W        = 27;
   localparam int OUT_ANGLE_W  = 15;
   localparam int RSP_W        = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int LANES        = 4;
   // normalize + square root + rotations + rounding
   localparam int TILT_LAT     = 1 + ISQRT_STEPS + CORDIC_STEPS + 1;

   localparam logic [TAB_W-1:0] Z_MAX = TAB_W'(90 << GUARD_FRAC);

   // atan(2^-i) in degrees, 2^-20 degree units
   localparam logic [TAB_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
      27'd1876857,  27'd938658,   27'd469357,   27'd234682,  27'd117342,
      27'd58671,    27'd29335,    27'd14668,    27'd7334,    27'd3667,
      27'd1833,     27'd917,      27'd458,      27'd229,     27'd115,
      27'd57,       27'd29,       27'd14,       27'd7,       27'd4,
      27'd2,        27'd1
   };

endpackage

[src/dat_front.sv]
// ----------------------------------------------------------------------------
// dat_front
// Takes sample words, forms axis magnitudes and squares, and builds the four
// angle jobs (numerator, sum of squares) for the queue.
// ----------------------------------------------------------------------------
module dat_front
   import dat_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [SAMPLE_WIDTH-1:0]        sample [0:5],
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [LANES*3*SAMPLE_WIDTH-1:0] push_data
);

   localparam int SW = SAMPLE_WIDTH;

   logic          st0_v_ff, st0_v_in, st1_v_ff, st1_v_in;
   logic          st0_adv, st1_adv;
   logic [SW-1:0] smp_ff [0:5];
   logic [SW-1:0] mag_ff [0:5];
   logic [SW-1:0] mag_in [0:5];
   logic [2*SW-1:0] sq_ff [0:5];
   logic [2*SW-1:0] sq_in [0:5];

   assign st1_adv    = !st1_v_ff || push_ready;
   assign st0_adv    = !st0_v_ff || st1_adv;
   assign in_ready   = st0_adv;
   assign push_valid = st1_v_ff;
   assign st0_v_in   = st0_adv ? in_valid : st0_v_ff;
   assign st1_v_in   = st1_adv ? st0_v_ff : st1_v_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         mag_in[k] = smp_ff[k][SW-1] ? (SW'(0) - smp_ff[k]) : smp_ff[k];
         sq_in[k]  = (2*SW)'(mag_in[k]) * (2*SW)'(mag_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_v_ff <= 1'b0;
         st1_v_ff <= 1'b0;
      end else begin
         st0_v_ff <= st0_v_in;
         st1_v_ff <= st1_v_in;
      end
      if (st0_adv && in_valid) begin
         smp_ff <= sample;
      end
      if (st1_adv && st0_v_ff) begin
         mag_ff <= mag_in;
         sq_ff  <= sq_in;
      end
   end

   // lanes: roll0, roll1, pitch0, pitch1; each {sum of squares, numerator}
   assign push_data = {
      sq_ff[3] + sq_ff[5], mag_ff[4],
      sq_ff[0] + sq_ff[2], mag_ff[1],
      sq_ff[4] + sq_ff[5], mag_ff[3],
      sq_ff[1] + sq_ff[2], mag_ff[0]
   };

endmodule

[src/dat_queue.sv]
// ----------------------------------------------------------------------------
// dat_queue
// Short flop queue between the front and the angle pipeline.
// ----------------------------------------------------------------------------
module dat_queue
   import dat_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != (PW+1)'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in     = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/dat_tilt.sv]
// ----------------------------------------------------------------------------
// dat_tilt
// One angle lane: normalize, pipelined integer square root, vectoring
// rotation pipeline, clamp and round. atan(n / sqrt(s)) in degrees.
// ----------------------------------------------------------------------------
module dat_tilt
   import dat_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [SAMPLE_WIDTH-1:0]     num,
   input  logic [2*SAMPLE_WIDTH-1:0]   sos,
   output logic [ANGLE_FRAC_BITS+6:0]  angle
);

   localparam int AW = ANGLE_FRAC_BITS + 7;
   localparam int SH = GUARD_FRAC - ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] FULL = AW'(90 << ANGLE_FRAC_BITS);
   localparam int SPC = ISQRT_STEPS + CORDIC_STEPS;

   // special codes: [0] force zero, [1] force full scale
   logic [1:0]          spc_ff [0:SPC];
   logic [NORM_S_W-1:0] v_ff [0:ISQRT_STEPS];
   logic [NORM_S_W-1:0] r_ff [0:ISQRT_STEPS];
   logic [NORM_N_W-1:0] n_ff [0:ISQRT_STEPS];
   logic [NORM_S_W-1:0] s_in;
   logic [NORM_N_W-1:0] n_in;
   logic [1:0]          spc_in;

   logic signed [XY_W-1:0] x_ff [1:CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff [1:CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [1:CORDIC_STEPS];

   logic [AW-1:0] angle_ff, angle_in;

   always_comb begin
      int amt;
      amt    = 0;
      s_in   = NORM_S_W'(sos);
      n_in   = NORM_N_W'(num);
      spc_in = {num != '0 && sos == '0, num == '0};
      for (int j = NORM_PASSES - 1; j >= 0; j--) begin
         amt = 1 << j;
         if (s_in < (NORM_S_W'(1) << (NORM_S_LIM - 2 * (amt - 1))) &&
             n_in < (NORM_N_W'(1) << (NORM_N_LIM - (amt - 1)))) begin
            s_in = s_in << (2 * amt);
            n_in = n_in << amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]   <= s_in;
         r_ff[0]   <= '0;
         n_ff[0]   <= n_in;
         spc_ff[0] <= spc_in;
         for (int k = 0; k < SPC; k++) begin
            spc_ff[k+1] <= spc_ff[k];
         end
      end
   end

   for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_sqrt
      localparam logic [NORM_S_W-1:0] BITV = NORM_S_W'(1) << (NORM_S_LIM - 2 * j);
      logic [NORM_S_W-1:0] tr, v_in, r_in;
      always_comb begin
         tr = r_ff[j] + BITV;
         if (v_ff[j] >= tr) begin
            v_in = v_ff[j] - tr;
            r_in = (r_ff[j] >> 1) + BITV;
         end else begin
            v_in = v_ff[j];
            r_in = r_ff[j] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[j+1] <= v_in;
            r_ff[j+1] <= r_in;
            n_ff[j+1] <= n_ff[j];
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [XY_W-1:0] xs, ys, dx, dy, x_in, y_in;
      logic signed [Z_W-1:0]  zs, tv, z_in;
      if (i == 0) begin : g_src
         assign xs = XY_W'(r_ff[ISQRT_STEPS][NORM_N_W-1:0]);
         assign ys = XY_W'(n_ff[ISQRT_STEPS]);
         assign zs = '0;
      end else begin : g_src
         assign xs = x_ff[i];
         assign ys = y_ff[i];
         assign zs = z_ff[i];
      end
      always_comb begin
         tv = Z_W'(ATAN_TAB[i]);
         dx = ys[XY_W-1] ? -((-ys) >>> i) : (ys >>> i);
         dy = xs >>> i;
         if (!ys[XY_W-1]) begin
            x_in = xs + dx;
            y_in = ys - dy;
            z_in = zs + tv;
         end else begin
            x_in = xs - dx;
            y_in = ys + dy;
            z_in = zs - tv;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   always_comb begin
      logic [TAB_W-1:0] zc;
      logic [TAB_W:0]   zr;
      logic [TAB_W:0]   rv;
      logic signed [Z_W-1:0] zf;
      zf = z_ff[CORDIC_STEPS];
      if (zf[Z_W-1]) begin
         zc = '0;
      end else if (zf > $signed({2'b00, Z_MAX})) begin
         zc = Z_MAX;
      end else begin
         zc = zf[TAB_W-1:0];
      end
      zr = {1'b0, zc} + (TAB_W+1)'(1 << (SH - 1));
      rv = zr >> SH;
      angle_in = (rv > (TAB_W+1)'(FULL)) ? FULL : AW'(rv);
      if (spc_ff[SPC][0]) begin
         angle_in = '0;
      end else if (spc_ff[SPC][1]) begin
         angle_in = FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

[src/dat_back.sv]
// ----------------------------------------------------------------------------
// dat_back
// Four angle lanes under one stall enable, sensor averaging and the result
// register.
// ----------------------------------------------------------------------------
module dat_back
   import dat_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  logic [LANES*3*SAMPLE_WIDTH-1:0] pop_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_W-1:0]                rsp_tdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int AW    = ANGLE_FRAC_BITS + 7;
   localparam int PAD_W = RSP_W - 2 * OUT_ANGLE_W;

   logic                   adv;
   logic                   vline_ff [0:TILT_LAT-1];
   logic                   rsp_v_ff, rsp_v_in;
   logic [AW-1:0]          ang [0:LANES-1];
   logic [AW:0]            roll_sum, pitch_sum;
   logic [OUT_ANGLE_W-1:0] roll_ff, roll_in, pitch_ff, pitch_in;

   assign adv       = !rsp_v_ff || rsp_tready;
   assign pop_ready = adv;
   assign rsp_v_in  = adv ? vline_ff[TILT_LAT-1] : rsp_v_ff;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      dat_tilt #(
         .SAMPLE_WIDTH    (SAMPLE_WIDTH),
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
      ) u_tilt (
         .clock (clock),
         .en    (adv),
         .num   (pop_data[k*3*SW +: SW]),
         .sos   (pop_data[k*3*SW+SW +: 2*SW]),
         .angle (ang[k])
      );
   end

   assign roll_sum  = (AW+1)'(ang[0]) + (AW+1)'(ang[1]);
   assign pitch_sum = (AW+1)'(ang[2]) + (AW+1)'(ang[3]);
   assign roll_in   = OUT_ANGLE_W'(roll_sum[AW:1]);
   assign pitch_in  = OUT_ANGLE_W'(pitch_sum[AW:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
         for (int k = 0; k < TILT_LAT; k++) begin
            vline_ff[k] <= 1'b0;
         end
      end else begin
         rsp_v_ff <= rsp_v_in;
         if (adv) begin
            vline_ff[0] <= pop_valid;
            for (int k = 1; k < TILT_LAT; k++) begin
               vline_ff[k] <= vline_ff[k-1];
            end
         end
      end
      if (adv && vline_ff[TILT_LAT-1]) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, pitch_ff, roll_ff};

endmodule

[src/dual_accel_tilt_angles.sv]
// ----------------------------------------------------------------------------
// dual_accel_tilt_angles
// Roll and pitch from two three-axis accelerometers, averaged.
// ----------------------------------------------------------------------------
// req channel: one word holds both sensors' x, y, z samples; an accepted word
// yields exactly one rsp word with the mean absolute roll and pitch in units
// of 2^-ANGLE_FRAC_BITS degree (0 to 90 degrees).
// Throughput: one word per cycle while rsp_tready is high; the front stages,
// the queue and the fully pipelined square root and rotation lanes each take
// a new word every cycle. Path from req acceptance to rsp_tvalid: 2 front
// stages, the queue register, 59 lane stages (normalize, 30 square root steps,
// 27 rotations, rounding) and the result register.
// Reset clears all valid flags and the queue pointers and count; data registers are not reset.
// When rsp_tready is low while a rsp word is held, the result register holds and
// the lanes freeze; the front keeps taking words until the 4-entry queue and
// both front stages fill, then req_tready drops.
// ----------------------------------------------------------------------------
module dual_accel_tilt_angles
   import dat_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sensor0_x, sensor0_y, sensor0_z, sensor1_x, sensor1_y, sensor1_z, zero fill
   input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // roll_angle[14:0], pitch_angle[29:15], zero fill
   output logic [RSP_W-1:0]                         rsp_tdata
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int EW = LANES * 3 * SW;

   logic [SW-1:0] sample [0:5];
   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [EW-1:0] push_data, pop_data;

   for (genvar k = 0; k < 6; k++) begin : g_unpack
      assign sample[k] = req_tdata[k*SW +: SW];
   end

   dat_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .sample     (sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   dat_queue #(.WIDTH(EW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dat_back #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[src/dat_checker.sv]
// ----------------------------------------------------------------------------
// dat_checker
// Port-level checks on the result channel of dual_accel_tilt_angles.
// ----------------------------------------------------------------------------
`include "dual_accel_tilt_angles_defines.svh"

module dat_checker
   import dat_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam logic [OUT_ANGLE_W-1:0] FULL = OUT_ANGLE_W'(90 << ANGLE_FRAC_BITS);
   localparam logic WIDE = ANGLE_FRAC_BITS > 8;

   `DAT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `DAT_ASSERT(a_rsp_pad, rsp_tvalid |-> rsp_tdata[31:30] == 2'b00, "rsp fill bits not zero")
   `DAT_ASSERT(a_rsp_range, rsp_tvalid |-> WIDE || (rsp_tdata[14:0] <= FULL && rsp_tdata[29:15] <= FULL), "angle above 90 degrees")
   `DAT_ASSERT_RST(a_rst_idle, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind dual_accel_tilt_angles dat_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dat_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dual_accel_tilt_angles: directed table plus random
// sample pairs, each rsp word compared with a known table angle or a local tilt angle predictor.
// ----------------------------------------------------------------------------
module tb;
   import dat_pkg::*;

   localparam int SW      = 16;
   localparam int FRAC    = 8;
   localparam int REQ_W   = ((6*SW+7)/8)*8;
   localparam int FULL    = 90 << FRAC;
   localparam int N_DIR   = 16;
   localparam int N_RAND  = 2000;
   localparam int WD_MAX  = 5000;
   localparam int DRAIN   = 120;

   typedef struct packed {
      logic [14:0] roll;
      logic [14:0] pitch;
   } angles_type;

   typedef struct {
      logic signed [SW-1:0] ax [6];
      bit                   known;
      angles_type           ang;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   angles_type pending_angles [$];
   int      n_mismatch = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;

   dual_accel_tilt_angles dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint sgn_shift(longint v, int i);
      return (v >= 0) ? (v >>> i) : -((-v) >>> i);
   endfunction

   // |atan(num / sqrt(a^2 + b^2))| in 2^-FRAC degree
   function automatic longint unsigned tilt_angle(longint num, longint a, longint b);
      longint unsigned n, s, r;
      longint x, y, z, dx, dy;
      n = (num < 0) ? -num : num;
      s = longint'(a*a) + longint'(b*b);
      z = 0;
      if (n == 0) return 0;
      if (s == 0) return FULL;
      while (s < (64'd1 << 58) && n < (64'd1 << 29)) begin
         s = s << 2;
         n = n << 1;
      end
      x = int_sqrt(s);
      y = n;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = sgn_shift(y, i);
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) << GUARD_FRAC)) z = longint'(90) << GUARD_FRAC;
      r = (z + (64'd1 << (GUARD_FRAC-FRAC-1))) >> (GUARD_FRAC-FRAC);
      if (r > FULL) r = FULL;
      return r;
   endfunction

   function automatic angles_type mean_tilt(logic signed [SW-1:0] ax [6]);
      angles_type a;
      longint unsigned r, p;
      r = (tilt_angle(ax[0], ax[1], ax[2]) + tilt_angle(ax[3], ax[4], ax[5])) >> 1;
      p = (tilt_angle(ax[1], ax[0], ax[2]) + tilt_angle(ax[4], ax[3], ax[5])) >> 1;
      a.roll  = r[14:0];
      a.pitch = p[14:0];
      return a;
   endfunction

   task automatic send_word(logic signed [SW-1:0] ax [6]);
      logic [REQ_W-1:0] w;
      w = '0;
      for (int k = 0; k < 6; k++) w[k*SW +: SW] = ax[k];
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_axes(output logic signed [SW-1:0] ax [6]);
      int mode;
      for (int k = 0; k < 6; k++) begin
         mode = $urandom_range(0, 9);
         case (mode)
            0: begin
               ax[k] = '0;
            end
            1: begin
               ax[k] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            end
            2: begin
               ax[k] = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            end
            default: begin
               ax[k] = SW'($urandom);
            end
         endcase
      end
   endtask

   task automatic gap();
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stimulus
   initial begin
      dir_row_type dir [N_DIR];
      logic signed [SW-1:0] ax [6];
      angles_type a;
      int burst;
      dir[0]  = '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0}};
      dir[1]  = '{'{100, 0, 0, -5, 0, 0}, 1, '{FULL, 0}};
      dir[2]  = '{'{0, 100, 0, 0, -7, 0}, 1, '{0, FULL}};
      dir[3]  = '{'{0, 0, 100, 0, 0, -1}, 1, '{0, 0}};
      dir[4]  = '{'{32767, 0, 0, 0, 0, 0}, 1, '{FULL/2, 0}};
      dir[5]  = '{'{-32768, -32768, 0, -32768, -32768, 0}, 0, '{0, 0}};
      dir[6]  = '{'{32767, 32767, 32767, 32767, 32767, 32767}, 0, '{0, 0}};
      dir[7]  = '{'{-32768, -32768, -32768, -32768, -32768, -32768}, 0, '{0, 0}};
      dir[8]  = '{'{1, 0, 32767, -1, 0, -32768}, 0, '{0, 0}};
      dir[9]  = '{'{-1, -1, 0, 1, 1, 0}, 0, '{0, 0}};
      dir[10] = '{'{1000, 0, 1000, 0, 1000, 1000}, 0, '{0, 0}};
      dir[11] = '{'{-32768, 1, 1, 1, -32768, 1}, 0, '{0, 0}};
      dir[12] = '{'{12345, -23456, 345, -4567, 5678, -16384}, 0, '{0, 0}};
      dir[13] = '{'{0, 0, -32768, 0, 0, 32767}, 1, '{0, 0}};
      dir[14] = '{'{-21846, 21845, -1, 21845, -21846, 0}, 0, '{0, 0}};
      dir[15] = '{'{32767, -32768, 0, 0, 0, 0}, 0, '{0, 0}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIR; i++) begin
         a = mean_tilt(dir[i].ax);
         if (dir[i].known && a != dir[i].ang)
            $display("table row %0d disagrees with predictor", i);
         pending_angles.push_back(dir[i].known ? dir[i].ang : a);
         send_word(dir[i].ax);
         gap();
      end
      for (int i = 0; i < N_RAND; ) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && i < N_RAND; j++, i++) begin
            random_axes(ax);
            pending_angles.push_back(mean_tilt(ax));
            send_word(ax);
         end
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clock);
         else @(posedge clock);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == 400) hold_off = 1'b1;
         if (cyc == 700) hold_off = 1'b0;
         if (hold_off) rsp_tready <= 1'b0;
         else if ((cyc / 256) % 3 == 2) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // checker
   always @(posedge clock) begin
      angles_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.roll  = rsp_tdata[14:0];
         got.pitch = rsp_tdata[29:15];
         if (pending_angles.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected rsp word %h", rsp_tdata);
         end else begin
            want = pending_angles.pop_front();
            if (got != want || rsp_tdata[RSP_W-1:30] != '0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                           want.roll, got.roll, want.pitch, got.pitch);
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      int tail;
      tail = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_MAX) begin
            $display("dual_accel_tilt_angles verification failed");
            $finish;
         end
         if (stim_done && pending_angles.size() == 0) tail++;
         if (tail >= DRAIN) begin
            if (n_mismatch == 0 && pending_angles.size() == 0)
               $display("dual_accel_tilt_angles verification clean");
            else
               $display("dual_accel_tilt_angles verification failed");
            $finish;
         end
      end
   end

endmodule
